// ===== rtl/brf_pkg.sv =====
`default_nettype none

package brf_pkg;

    // Ring geometry. Pointer and level widths are those of the interface fields.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = 8;
    localparam int CNT_W  = 9;

    localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(DEPTH);
    localparam logic [7:0]       FREED_MARK = 8'hFE;

    // Command codes carried on the request channel.
    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_GET   = 3'd2,
        CMD_ERASE = 3'd3,
        CMD_FIND  = 3'd4,
        CMD_FLUSH = 3'd5
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        cmd_t op;
        logic erase_step;
        logic scan_step;
        logic load;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic erase_ok;
        logic erase_zero;
        logic erase_last;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/brf_req_if.sv =====
`default_nettype none

interface brf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] byte_value;
    logic [7:0] peek_index;
    logic [8:0] erase_count;
    logic       clear_store;

    modport source (
        output valid, command, byte_value, peek_index, erase_count, clear_store,
        input  ready
    );

    modport sink (
        input  valid, command, byte_value, peek_index, erase_count, clear_store,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/brf_rsp_if.sv =====
`default_nettype none

interface brf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       success;
    logic       overwrote;
    logic [8:0] fill_level;
    logic       is_empty;
    logic       is_full;

    modport source (
        output valid, read_byte, success, overwrote, fill_level, is_empty, is_full,
        input  ready
    );

    modport sink (
        input  valid, read_byte, success, overwrote, fill_level, is_empty, is_full,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/brf_ctrl.sv =====
`default_nettype none

module brf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic [2:0]       command,
    input  wire brf_pkg::status_t sts,
    output brf_pkg::ctrl_t        ctl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ERASE = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    state_t        after_accept;
    brf_pkg::cmd_t op;
    logic          accept;
    logic          load;

    assign op = brf_pkg::cmd_t'(command);

    // A transaction is taken when idle, or when the pending result leaves this cycle.
    assign load      = (state_reg == ST_DONE) && sts.out_free;
    assign req_ready = (state_reg == ST_IDLE) || load;
    assign accept    = req_valid && req_ready;

    // A valid nonzero erase and a find on a non-empty ring walk the store; all else finishes at once.
    always_comb
    begin
        after_accept = ST_DONE;
        case (op)
            brf_pkg::CMD_ERASE:
            begin
                if (sts.erase_ok && !sts.erase_zero)
                begin
                    after_accept = ST_ERASE;
                end
            end
            brf_pkg::CMD_FIND:
            begin
                if (!sts.count_zero)
                begin
                    after_accept = ST_SCAN;
                end
            end
            default:
            begin
                after_accept = ST_DONE;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = after_accept;
                end
            end
            ST_ERASE:
            begin
                if (sts.erase_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (accept)
                begin
                    state_next = after_accept;
                end
                else if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign ctl.accept     = accept;
    assign ctl.op         = op;
    assign ctl.erase_step = (state_reg == ST_ERASE);
    assign ctl.scan_step  = (state_reg == ST_SCAN);
    assign ctl.load       = load;

endmodule

`default_nettype wire

// ===== rtl/brf_dp.sv =====
`default_nettype none

module brf_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire brf_pkg::ctrl_t             ctl,
    input  wire logic [7:0]                 byte_value,
    input  wire logic [7:0]                 peek_index,
    input  wire logic [8:0]                 erase_count,
    input  wire logic                       clear_store,
    input  wire logic                       rsp_ready,
    output logic                            rsp_valid,
    output logic [7:0]                      read_byte,
    output logic                            success,
    output logic                            overwrote,
    output logic [8:0]                      fill_level,
    output logic                            is_empty,
    output logic                            is_full,
    output brf_pkg::status_t                sts
);

    localparam int AW = brf_pkg::ADDR_W;
    localparam int CW = brf_pkg::CNT_W;

    // Byte store with one flag per entry; an entry without its flag reads as zero.
    logic [7:0]              store_reg [brf_pkg::DEPTH];
    logic [brf_pkg::DEPTH-1:0] valid_reg;

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] erase_cnt_reg, erase_cnt_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_pend_reg, cmp_pend_next;
    logic [7:0]    find_val_reg;
    logic          ok_reg, ok_next;
    logic          ow_reg, ow_next;
    logic          use_rd_reg, use_rd_next;
    logic [7:0]    rdata_reg;
    logic          rd_valid_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_ok_reg;
    logic          out_ow_reg;
    logic [CW-1:0] out_level_reg;

    logic          do_push, do_pop, do_get, do_erase, do_find, do_flush;
    logic          count_zero, full, pop_one;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rd_byte;
    logic          scan_issue, scan_hit;

    // Command decode.
    assign do_push  = ctl.accept && (ctl.op == brf_pkg::CMD_PUSH);
    assign do_pop   = ctl.accept && (ctl.op == brf_pkg::CMD_POP);
    assign do_get   = ctl.accept && (ctl.op == brf_pkg::CMD_GET);
    assign do_erase = ctl.accept && (ctl.op == brf_pkg::CMD_ERASE);
    assign do_find  = ctl.accept && (ctl.op == brf_pkg::CMD_FIND);
    assign do_flush = ctl.accept && (ctl.op == brf_pkg::CMD_FLUSH);

    assign count_zero = (count_reg == '0);
    assign full       = (count_reg == brf_pkg::FULL_LEVEL);

    // One entry leaves the ring on a non-empty pop and on every erase step.
    assign pop_one = (do_pop && !count_zero) || ctl.erase_step;

    // Find: one read issued per cycle, and each read byte is compared in the cycle after its issue.
    assign rd_byte    = rd_valid_reg ? rdata_reg : 8'h00;
    assign scan_issue = (scan_idx_reg < count_reg);
    assign scan_hit   = cmp_pend_reg && (rd_byte == find_val_reg);

    // Store port control.
    assign mem_we    = do_push || pop_one;
    assign mem_waddr = do_push ? wp_reg : rp_reg;
    assign mem_wdata = do_push ? byte_value : brf_pkg::FREED_MARK;

    assign mem_re = (do_pop && !count_zero) || do_get || (ctl.scan_step && scan_issue);

    always_comb
    begin
        if (do_get)
        begin
            mem_raddr = rp_reg + peek_index;
        end
        else if (ctl.scan_step)
        begin
            mem_raddr = rp_reg + scan_idx_reg[AW-1:0];
        end
        else
        begin
            mem_raddr = rp_reg;
        end
    end

    // Pointers and level.
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wp_next = wp_reg + 1'b1;
            if (full)
            begin
                rp_next = rp_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (pop_one)
        begin
            rp_next    = rp_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (do_flush)
        begin
            wp_next    = '0;
            rp_next    = '0;
            count_next = '0;
        end
    end

    // Result flags held until the result is loaded.
    always_comb
    begin
        ok_next     = ok_reg;
        ow_next     = ow_reg;
        use_rd_next = use_rd_reg;
        if (ctl.accept)
        begin
            ok_next     = ((do_pop || do_get) && !count_zero) || (do_erase && sts.erase_ok);
            ow_next     = do_push && full;
            use_rd_next = (do_pop || do_get) && !count_zero;
        end
        else if (ctl.scan_step)
        begin
            ok_next = scan_hit;
        end
    end

    // Erase and scan counters.
    always_comb
    begin
        erase_cnt_next = erase_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_pend_next  = cmp_pend_reg;
        if (do_erase)
        begin
            erase_cnt_next = erase_count;
        end
        else if (ctl.erase_step)
        begin
            erase_cnt_next = erase_cnt_reg - 1'b1;
        end
        if (do_find)
        begin
            scan_idx_next = '0;
            cmp_pend_next = 1'b0;
        end
        else if (ctl.scan_step)
        begin
            scan_idx_next = scan_idx_reg + CW'(scan_issue);
            cmp_pend_next = scan_issue;
        end
    end

    // Output register valid.
    always_comb
    begin
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            erase_cnt_reg <= '0;
            scan_idx_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            ok_reg        <= 1'b0;
            ow_reg        <= 1'b0;
            use_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            erase_cnt_reg <= erase_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            ok_reg        <= ok_next;
            ow_reg        <= ow_next;
            use_rd_reg    <= use_rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Entry flags: reset and a clearing flush drop them all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (do_flush && clear_store)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // Store array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg    <= store_reg[mem_raddr];
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (do_find)
        begin
            find_val_reg <= byte_value;
        end
        if (ctl.load)
        begin
            out_byte_reg  <= use_rd_reg ? rd_byte : 8'h00;
            out_ok_reg    <= ok_reg;
            out_ow_reg    <= ow_reg;
            out_level_reg <= count_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign read_byte  = out_byte_reg;
    assign success    = out_ok_reg;
    assign overwrote  = out_ow_reg;
    assign fill_level = out_level_reg;
    assign is_empty   = (out_level_reg == '0);
    assign is_full    = (out_level_reg == brf_pkg::FULL_LEVEL);

    // Status to the controller.
    assign sts.count_zero = count_zero;
    assign sts.erase_ok   = (erase_count <= count_reg);
    assign sts.erase_zero = (erase_count == '0);
    assign sts.erase_last = (erase_cnt_reg == CW'(1));
    assign sts.scan_done  = scan_hit || !scan_issue;
    assign sts.out_free   = !out_valid_reg || rsp_ready;

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo_overwrite_core.sv =====
`default_nettype none

// Byte ring FIFO of 256 entries that overwrites its oldest byte when a push
// finds it full. Every request transaction yields exactly one response
// transaction, in order. Push, pop, get, flush and the unused codes are taken
// one per cycle while the response channel keeps up, and each result passes
// through the done state into the output register. While a result waits in
// the output register one further request is still taken; the block then
// holds off new requests until the response channel takes the waiting result.
// Erase of N entries occupies the block while the single store write port
// marks one freed slot a cycle. Find reads one live entry per cycle through
// the single store read port and stops on the first match. The store is
// cleared at reset and by a clearing flush all at once through one flag per
// entry, so there is no clearing pass after reset.
module byte_ring_fifo_overwrite_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    brf_req_if.sink    request,
    brf_rsp_if.source  response
);

    brf_pkg::ctrl_t   ctl;
    brf_pkg::status_t sts;
    logic             req_ready;

    assign request.ready = req_ready;

    // Sequencing of commands.
    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .command   (request.command),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Store, pointers and result register.
    brf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .byte_value  (request.byte_value),
        .peek_index  (request.peek_index),
        .erase_count (request.erase_count),
        .clear_store (request.clear_store),
        .rsp_ready   (response.ready),
        .rsp_valid   (response.valid),
        .read_byte   (response.read_byte),
        .success     (response.success),
        .overwrote   (response.overwrote),
        .fill_level  (response.fill_level),
        .is_empty    (response.is_empty),
        .is_full     (response.is_full),
        .sts         (sts)
    );

    // After an accepted push and the done state that follows it, response valid is always high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && req_ready && (request.command == brf_pkg::CMD_PUSH))
        |-> ##2 response.valid)
        else $error("push transaction produced no response");

    // A loaded result is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> response.valid)
        else $error("result load did not raise response valid");

    // The reported level never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (response.fill_level <= brf_pkg::FULL_LEVEL))
        else $error("fill level beyond ring depth");

    // No request is taken while the store is being walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.erase_step || ctl.scan_step) |-> !req_ready)
        else $error("request accepted during erase or find");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Codes left unused by the command set; the block must treat them as no-ops.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 100;

    typedef struct packed {
        logic [2:0]                command;
        logic [7:0]                byte_value;
        logic [7:0]                peek_index;
        logic [brf_pkg::CNT_W-1:0] erase_count;
        logic                      clear_store;
    } ring_cmd_t;

    typedef struct packed {
        logic [7:0]                read_byte;
        logic                      success;
        logic                      overwrote;
        logic [brf_pkg::CNT_W-1:0] fill_level;
        logic                      is_empty;
        logic                      is_full;
    } ring_result_t;

    logic clk;
    logic rst_n;

    brf_req_if req_bus ();
    brf_rsp_if rsp_bus ();

    byte_ring_fifo_overwrite_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_bus),
        .response (rsp_bus)
    );

    // Commands waiting to be offered, and results waiting to come back.
    ring_cmd_t    pending_cmds[$];
    ring_result_t ring_expect[$];

    // Shadow copy of the ring used to predict every result.
    logic [7:0]                 ring_bytes [brf_pkg::DEPTH];
    logic [brf_pkg::ADDR_W-1:0] head_ptr;
    logic [brf_pkg::ADDR_W-1:0] tail_ptr;
    logic [brf_pkg::CNT_W-1:0]  held;

    int  failures = 0;
    int  accepted_cmds = 0;
    bit  req_took;
    bit  rsp_took;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  calm_tx = 0;
    int  calm_rx = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    // Level as the stimulus generator believes it, used to aim erase and find.
    int         plan_level = 0;
    logic [7:0] last_pushed = 8'h00;

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [brf_pkg::ADDR_W-1:0] ring_step(logic [brf_pkg::ADDR_W-1:0] p);
        return brf_pkg::ADDR_W'((int'(p) + 1) % brf_pkg::DEPTH);
    endfunction

    // Removes the oldest byte and leaves the freed marker in its slot.
    function automatic logic [7:0] take_oldest();
        logic [7:0] b;
        b = ring_bytes[tail_ptr];
        ring_bytes[tail_ptr] = brf_pkg::FREED_MARK;
        tail_ptr = ring_step(tail_ptr);
        held = held - 1'b1;
        return b;
    endfunction

    // Applies one command to the shadow ring and returns the result it causes.
    function automatic ring_result_t apply_ring_command(ring_cmd_t c);
        ring_result_t r;
        r = '0;
        case (c.command)
            brf_pkg::CMD_PUSH:
            begin
                ring_bytes[head_ptr] = c.byte_value;
                head_ptr = ring_step(head_ptr);
                if (held < brf_pkg::FULL_LEVEL)
                    held = held + 1'b1;
                else
                begin
                    tail_ptr = ring_step(tail_ptr);
                    r.overwrote = 1'b1;
                end
            end
            brf_pkg::CMD_POP:
            begin
                if (held != 0)
                begin
                    r.read_byte = take_oldest();
                    r.success = 1'b1;
                end
            end
            brf_pkg::CMD_GET:
            begin
                if (held != 0)
                begin
                    r.read_byte = ring_bytes[brf_pkg::ADDR_W'(
                        (int'(tail_ptr) + int'(c.peek_index)) % brf_pkg::DEPTH)];
                    r.success = 1'b1;
                end
            end
            brf_pkg::CMD_ERASE:
            begin
                if (c.erase_count <= held)
                begin
                    for (int i = 0; i < int'(c.erase_count); i++)
                        void'(take_oldest());
                    r.success = 1'b1;
                end
            end
            brf_pkg::CMD_FIND:
            begin
                for (int i = 0; i < int'(held); i++)
                begin
                    if (ring_bytes[brf_pkg::ADDR_W'((int'(tail_ptr) + i) % brf_pkg::DEPTH)]
                        == c.byte_value)
                    begin
                        r.success = 1'b1;
                        break;
                    end
                end
            end
            brf_pkg::CMD_FLUSH:
            begin
                held = '0;
                head_ptr = '0;
                tail_ptr = '0;
                if (c.clear_store)
                    foreach (ring_bytes[i])
                        ring_bytes[i] = 8'h00;
            end
            default:
            begin
            end
        endcase
        r.fill_level = held;
        r.is_empty = (held == 0);
        r.is_full = (held == brf_pkg::FULL_LEVEL);
        return r;
    endfunction

    // Gap lengths: mostly none or short, a few long, with calm stretches of none.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void compare_field(string name, logic [8:0] exp_v, logic [8:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            failures++;
        end
    endfunction

    // Queues one command and keeps the generator's idea of the level up to date.
    task automatic plan_command(logic [2:0] cmd, logic [7:0] val, logic [7:0] idx,
                                logic [brf_pkg::CNT_W-1:0] cnt, logic clr);
        ring_cmd_t c;
        c = '{command: cmd, byte_value: val, peek_index: idx, erase_count: cnt, clear_store: clr};
        pending_cmds.push_back(c);
        case (cmd)
            brf_pkg::CMD_PUSH:
            begin
                last_pushed = val;
                if (plan_level < brf_pkg::DEPTH)
                    plan_level++;
            end
            brf_pkg::CMD_POP:
                if (plan_level > 0)
                    plan_level--;
            brf_pkg::CMD_ERASE:
                if (int'(cnt) <= plan_level)
                    plan_level -= int'(cnt);
            brf_pkg::CMD_FLUSH:
                plan_level = 0;
            default:
            begin
            end
        endcase
    endtask

    // One random command with random content in the fields it does not use.
    task automatic plan_random_command();
        int roll;
        logic [7:0] val;
        logic [brf_pkg::CNT_W-1:0] cnt;
        roll = $urandom_range(0, 99);
        val = 8'($urandom);
        cnt = brf_pkg::CNT_W'($urandom_range(0, brf_pkg::DEPTH));
        if (roll < 38)
            plan_command(brf_pkg::CMD_PUSH, val, 8'($urandom), cnt, 1'($urandom));
        else if (roll < 52)
            plan_command(brf_pkg::CMD_POP, val, 8'($urandom), cnt, 1'($urandom));
        else if (roll < 66)
            plan_command(brf_pkg::CMD_GET, val, 8'($urandom), cnt, 1'($urandom));
        else if (roll < 76)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                cnt = brf_pkg::CNT_W'($urandom_range(0, (plan_level < 8) ? plan_level : 8));
            else if (roll < 85 || plan_level >= brf_pkg::DEPTH)
                cnt = brf_pkg::CNT_W'($urandom_range(0, plan_level));
            else
                cnt = brf_pkg::CNT_W'($urandom_range(plan_level + 1, brf_pkg::DEPTH));
            plan_command(brf_pkg::CMD_ERASE, val, 8'($urandom), cnt, 1'($urandom));
        end
        else if (roll < 90)
        begin
            if ($urandom_range(0, 1) == 1)
                val = last_pushed;
            plan_command(brf_pkg::CMD_FIND, val, 8'($urandom), cnt, 1'($urandom));
        end
        else if (roll < 96)
            plan_command(brf_pkg::CMD_FLUSH, val, 8'($urandom), cnt, 1'($urandom));
        else
            plan_command(($urandom_range(0, 1) == 1) ? CMD_SPARE_7 : CMD_SPARE_6,
                         val, 8'($urandom), cnt, 1'($urandom));
    endtask

    // Fills the ring, overwrites past full, probes it and then erases everything.
    task automatic plan_fill_and_drain();
        while (plan_level < brf_pkg::DEPTH)
            plan_command(brf_pkg::CMD_PUSH, 8'($urandom), 8'($urandom), 9'd0, 1'b0);
        repeat ($urandom_range(3, 8))
            plan_command(brf_pkg::CMD_PUSH, 8'($urandom), 8'($urandom), 9'd0, 1'b0);
        repeat (4)
            plan_command(brf_pkg::CMD_GET, 8'($urandom), 8'($urandom), 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FIND, last_pushed, 8'd0, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FIND, 8'($urandom), 8'd0, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_POP, 8'd0, 8'd0, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_PUSH, 8'($urandom), 8'd0, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'd0, 8'd0, brf_pkg::CNT_W'(brf_pkg::DEPTH), 1'b0);
    endtask

    // Request driver: a new transaction is offered at the falling edge once the
    // previous one has been taken and the chosen gap has passed.
    always @(negedge clk)
    begin : drive_requests
        ring_cmd_t nxt;
        int g;
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (!req_bus.valid || req_took)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_bus.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                g = pick_gap(calm_tx);
                req_bus.command     <= nxt.command;
                req_bus.byte_value  <= nxt.byte_value;
                req_bus.peek_index  <= nxt.peek_index;
                req_bus.erase_count <= nxt.erase_count;
                req_bus.clear_store <= nxt.clear_store;
                req_bus.valid       <= 1'b1;
                send_gap <= (hold_left > 0) ? 0 : g;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Long hold-off of the response side, once, so that the block backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && accepted_cmds >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // Response ready: random stalls after each transaction, and the hold-off.
    always @(negedge clk)
    begin : drive_ready
        int g;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            g = rsp_took ? pick_gap(calm_rx) : recv_gap;
            if (hold_left > 0)
                rsp_bus.ready <= 1'b0;
            else if (g > 0)
            begin
                rsp_bus.ready <= 1'b0;
                recv_gap <= g - 1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    // Monitor: predicts each accepted command and checks each accepted result.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        ring_result_t e;
        if (!rst_n)
        begin
            req_took <= 1'b0;
            rsp_took <= 1'b0;
        end
        else
        begin
            req_took <= req_bus.valid && req_bus.ready;
            rsp_took <= rsp_bus.valid && rsp_bus.ready;
            if (req_bus.valid && req_bus.ready)
            begin
                ring_expect.push_back(apply_ring_command('{
                    command:     req_bus.command,
                    byte_value:  req_bus.byte_value,
                    peek_index:  req_bus.peek_index,
                    erase_count: req_bus.erase_count,
                    clear_store: req_bus.clear_store}));
                accepted_cmds++;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (ring_expect.size() == 0)
                begin
                    $display("%0t: result transaction with no command outstanding", $time);
                    failures++;
                end
                else
                begin
                    e = ring_expect.pop_front();
                    compare_field("read_byte", 9'(e.read_byte), 9'(rsp_bus.read_byte));
                    compare_field("success", 9'(e.success), 9'(rsp_bus.success));
                    compare_field("overwrote", 9'(e.overwrote), 9'(rsp_bus.overwrote));
                    compare_field("fill_level", e.fill_level, rsp_bus.fill_level);
                    compare_field("is_empty", 9'(e.is_empty), 9'(rsp_bus.is_empty));
                    compare_field("is_full", 9'(e.is_full), 9'(rsp_bus.is_full));
                end
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        int fill_at;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.command = brf_pkg::CMD_PUSH;
        req_bus.byte_value = 8'h00;
        req_bus.peek_index = 8'h00;
        req_bus.erase_count = '0;
        req_bus.clear_store = 1'b0;
        rsp_bus.ready = 1'b0;
        foreach (ring_bytes[i])
            ring_bytes[i] = 8'h00;
        head_ptr = '0;
        tail_ptr = '0;
        held = '0;

        // Empty ring: pop, get and the erase limits.
        plan_command(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'hFF, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'h00, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'h00, 8'h00, 9'd1, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'h00, 8'h00, brf_pkg::CNT_W'(brf_pkg::DEPTH), 1'b0);
        // A few entries with extreme values, then peeks inside and past the count, and two finds.
        plan_command(brf_pkg::CMD_PUSH, 8'h00, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_PUSH, 8'hFF, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_PUSH, 8'hA5, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'hFF, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'h02, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FIND, 8'hFF, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FIND, 8'h3C, 8'h00, 9'd0, 1'b0);
        // Pop leaves the freed marker, which a peek past the count then sees.
        plan_command(brf_pkg::CMD_POP, 8'h00, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'hFF, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'h00, 8'h00, 9'd3, 1'b0);
        plan_command(brf_pkg::CMD_ERASE, 8'h00, 8'h00, 9'd2, 1'b0);
        plan_command(CMD_SPARE_6, 8'hFF, 8'hFF, 9'd1, 1'b1);
        plan_command(CMD_SPARE_7, 8'h00, 8'h00, 9'd0, 1'b0);
        // Flush without and with clearing the store.
        plan_command(brf_pkg::CMD_PUSH, 8'h5A, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FLUSH, 8'h00, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_PUSH, 8'h11, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'h01, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_FLUSH, 8'h00, 8'h00, 9'd0, 1'b1);
        plan_command(brf_pkg::CMD_PUSH, 8'h22, 8'h00, 9'd0, 1'b0);
        plan_command(brf_pkg::CMD_GET, 8'h00, 8'h01, 9'd0, 1'b0);

        // Random part, with one full-ring episode somewhere along the way.
        fill_at = pending_cmds.size() + $urandom_range(50, 200);
        while (pending_cmds.size() < 25 + RANDOM_ITEMS)
        begin
            if (fill_at >= 0 && pending_cmds.size() >= fill_at)
            begin
                plan_fill_and_drain();
                fill_at = -1;
            end
            else
                plan_random_command();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (ring_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
